// ===== design/led_matrix_scan_controller_unit_assert.svh =====
// ----------------------------------------------------------------------------
// LED matrix scan controller assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_SCAN_CONTROLLER_UNIT_ASSERT_SVH
`define LED_MATRIX_SCAN_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked while reset is released.
`define LMSC_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define LMSC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/lmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan controller package
// Geometry constants, shared types and the reset pattern of the frame store.
// ----------------------------------------------------------------------------
package lmsc_pkg;

    localparam int SCAN_ROWS      = 16;
    localparam int PIXELS_PER_ROW = 48;
    localparam int BYTES_PER_ROW  = (PIXELS_PER_ROW + 7) / 8;
    localparam int FRAME_BYTES    = SCAN_ROWS * BYTES_PER_ROW;
    localparam int ROW_W          = $clog2(SCAN_ROWS);
    localparam int GRP_W          = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
    localparam int BIT_W          = $clog2(PIXELS_PER_ROW);
    localparam int INDEX_W        = 7;
    localparam int VALUE_W        = 8;
    localparam int COLUMN_W       = 4;
    localparam int BITS_W         = 48;

    // The byte index is split into row and group by a rounded-up reciprocal,
    // which is exact for every index the port can carry.
    localparam int DIV_SHIFT      = 16;
    localparam int BYTE_RECIP     = ((1 << DIV_SHIFT) + BYTES_PER_ROW - 1) / BYTES_PER_ROW;

    typedef logic [PIXELS_PER_ROW-1:0] pixel_word_t;
    typedef logic [ROW_W-1:0]          row_t;
    typedef logic [GRP_W-1:0]          grp_t;
    typedef logic [BIT_W-1:0]          bit_cnt_t;

    typedef struct packed {
        logic latch;
        logic write_en;
        logic load;
        logic shift_en;
        logic emit;
    } dp_cmd_t;

    function automatic pixel_word_t diag_word(input int r);
        pixel_word_t w;
        w = '0;
        if (r < PIXELS_PER_ROW)
        begin
            w[r] = 1'b1;
        end
        return w;
    endfunction

endpackage

// ===== design/lmsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan controller sequencer
// Steps each transfer through byte write or blanking, shift-out and result.
// ----------------------------------------------------------------------------
module lmsc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             command,
    output logic             busy,
    output lmsc_pkg::dp_cmd_t dp_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WRITE = 5'b00010,
        ST_BLANK = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    localparam lmsc_pkg::bit_cnt_t CNT_LAST = lmsc_pkg::bit_cnt_t'(lmsc_pkg::PIXELS_PER_ROW - 1);

    state_t             state_reg;
    state_t             state_next;
    lmsc_pkg::bit_cnt_t cnt_reg;
    lmsc_pkg::bit_cnt_t cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dp_cmd     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    dp_cmd.latch = 1'b1;
                    state_next   = command ? ST_BLANK : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                dp_cmd.write_en = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_BLANK:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    dp_cmd.load = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_SHIFT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SHIFT:
            begin
                dp_cmd.shift_en = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                dp_cmd.emit = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== design/lmsc_dpath.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan controller datapath
// Frame store, byte placement, column shift register and result registers.
// ----------------------------------------------------------------------------
module lmsc_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lmsc_pkg::dp_cmd_t                  dp_cmd,
    input  logic [lmsc_pkg::INDEX_W-1:0]       byte_index,
    input  logic [lmsc_pkg::VALUE_W-1:0]       byte_value,
    input  logic                               frame_start,
    output logic                               done,
    output logic [lmsc_pkg::COLUMN_W-1:0]      column_index,
    output logic [lmsc_pkg::BITS_W-1:0]        column_bits,
    output logic                               pin_pa,
    output logic                               pin_pb,
    output logic                               pin_na,
    output logic                               pin_nb,
    output logic                               frame_done
);

    localparam lmsc_pkg::row_t ROW_LAST = lmsc_pkg::row_t'(lmsc_pkg::SCAN_ROWS - 1);

    logic [lmsc_pkg::INDEX_W-1:0] index_reg;
    logic [lmsc_pkg::VALUE_W-1:0] value_reg;
    logic                         fstart_reg;

    lmsc_pkg::pixel_word_t store_reg [lmsc_pkg::SCAN_ROWS];
    lmsc_pkg::pixel_word_t shift_reg;
    lmsc_pkg::pixel_word_t capture_reg;
    lmsc_pkg::row_t        col_reg;

    logic                         done_reg;
    logic [lmsc_pkg::COLUMN_W-1:0] column_index_reg;
    logic [lmsc_pkg::BITS_W-1:0]  column_bits_reg;
    logic                         frame_done_reg;

    logic                  index_ok;
    logic [31:0]           div_prod;
    logic [31:0]           div_quot;
    logic [31:0]           div_rem;
    lmsc_pkg::row_t        wr_row;
    lmsc_pkg::grp_t        wr_grp;
    logic [63:0]           wide_bits;
    lmsc_pkg::pixel_word_t wr_bits;
    logic [63:0]           col_ext;
    logic [63:0]           cap_ext;

    assign index_ok  = (32'(index_reg) < lmsc_pkg::FRAME_BYTES);
    assign div_prod  = 32'(index_reg) * 32'(lmsc_pkg::BYTE_RECIP);
    assign div_quot  = div_prod >> lmsc_pkg::DIV_SHIFT;
    assign div_rem   = 32'(index_reg) - div_quot * 32'(lmsc_pkg::BYTES_PER_ROW);
    assign wr_row    = lmsc_pkg::row_t'(div_quot);
    assign wr_grp    = lmsc_pkg::grp_t'(div_rem);
    assign wide_bits = 64'(value_reg) << {wr_grp, 3'b000};
    assign wr_bits   = lmsc_pkg::pixel_word_t'(wide_bits);
    assign col_ext   = 64'(col_reg);
    assign cap_ext   = 64'(capture_reg);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.latch)
        begin
            index_reg  <= byte_index;
            value_reg  <= byte_value;
            fstart_reg <= frame_start;
        end
        if (dp_cmd.load)
        begin
            shift_reg <= store_reg[col_reg];
        end
        else if (dp_cmd.shift_en)
        begin
            shift_reg   <= shift_reg << 1;
            capture_reg <= {capture_reg[lmsc_pkg::PIXELS_PER_ROW-2:0],
                            shift_reg[lmsc_pkg::PIXELS_PER_ROW-1]};
        end
        if (dp_cmd.emit)
        begin
            column_index_reg <= col_ext[lmsc_pkg::COLUMN_W-1:0];
            column_bits_reg  <= cap_ext[lmsc_pkg::BITS_W-1:0];
            frame_done_reg   <= (col_reg == ROW_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < lmsc_pkg::SCAN_ROWS; r++)
            begin
                store_reg[r] <= lmsc_pkg::diag_word(r);
            end
            col_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dp_cmd.emit;
            if (dp_cmd.write_en)
            begin
                for (int r = 0; r < lmsc_pkg::SCAN_ROWS; r++)
                begin
                    if (fstart_reg)
                    begin
                        store_reg[r] <= (index_ok && wr_row == lmsc_pkg::row_t'(r)) ?
                                        wr_bits : '0;
                    end
                    else if (index_ok && wr_row == lmsc_pkg::row_t'(r))
                    begin
                        store_reg[r] <= store_reg[r] | wr_bits;
                    end
                end
            end
            if (dp_cmd.emit)
            begin
                col_reg <= (col_reg == ROW_LAST) ? '0 : col_reg + 1'b1;
            end
        end
    end

    assign done         = done_reg;
    assign column_index = column_index_reg;
    assign column_bits  = column_bits_reg;
    assign pin_pa       = column_index_reg[3] ^ column_index_reg[2];
    assign pin_pb       = column_index_reg[3];
    assign pin_na       = column_index_reg[1] ^ column_index_reg[0];
    assign pin_nb       = column_index_reg[1];
    assign frame_done   = frame_done_reg;

endmodule

// ===== design/led_matrix_scan_controller_unit.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan controller
// Multiplexed 16 by 48 LED frame store with serial column refresh.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. A byte write keeps
// the block busy for a single cycle, so writes cannot be taken back to back.
// A scan tick runs a blanking interval and a serial shift-out of the column
// word, both paced by the one bit counter of the sequencer, and then the emit
// state, whose strobe is registered into done; busy drops in the cycle done is
// high, and the next transfer can be taken at the edge that takes the result.
// The result ports hold their values until the next scan tick completes, but
// the receiver cannot stall: it must take the result in the cycle done is high.
// After reset the store holds a diagonal test pattern and the scan starts at
// column zero.
module led_matrix_scan_controller_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic [lmsc_pkg::INDEX_W-1:0]       byte_index,
    input  logic [lmsc_pkg::VALUE_W-1:0]       byte_value,
    input  logic                               frame_start,
    output logic                               done,
    output logic [lmsc_pkg::COLUMN_W-1:0]      column_index,
    output logic [lmsc_pkg::BITS_W-1:0]        column_bits,
    output logic                               pin_pa,
    output logic                               pin_pb,
    output logic                               pin_na,
    output logic                               pin_nb,
    output logic                               frame_done
);

    lmsc_pkg::dp_cmd_t dp_cmd;

    lmsc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .dp_cmd  (dp_cmd)
    );

    lmsc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .frame_start  (frame_start),
        .done         (done),
        .column_index (column_index),
        .column_bits  (column_bits),
        .pin_pa       (pin_pa),
        .pin_pb       (pin_pb),
        .pin_na       (pin_na),
        .pin_nb       (pin_nb),
        .frame_done   (frame_done)
    );

endmodule

// ===== design/lmsc_checker.sv =====
// ----------------------------------------------------------------------------
// LED matrix scan controller port checker
// Watches the result strobe and row-select pins against the handshake.
// ----------------------------------------------------------------------------
`include "led_matrix_scan_controller_unit_assert.svh"

module lmsc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          busy,
    input logic                          done,
    input logic [lmsc_pkg::COLUMN_W-1:0] column_index,
    input logic                          pin_pb,
    input logic                          pin_na
);

    `LMSC_ASSERT_IMPLY(a_done_after_busy, clk, rst_n, done, $past(busy), "result without work")
    `LMSC_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy, "result while still busy")
    `LMSC_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe longer than one cycle")
    `LMSC_ASSERT_IMPLY(a_pins_gray, clk, rst_n, done, (pin_pb == column_index[3]) && (pin_na == (column_index[1] ^ column_index[0])), "row select does not match column")

endmodule

bind led_matrix_scan_controller_unit lmsc_checker u_lmsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .done         (done),
    .column_index (column_index),
    .pin_pb       (pin_pb),
    .pin_na       (pin_na)
);
